// File: rtl/dlpd_pkg.sv
package dlpd_pkg;

	// Default length counter width
	localparam int LEN_BITS_DEF = 31;

	// Result queue depth (power of two, at least 2)
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes
	localparam logic CFG_HDR_SKIP  = 1'b0;
	localparam logic CFG_LEN_LIMIT = 1'b1;

	// Configuration reset values
	localparam logic [7:0]  HDR_SKIP_RESET  = 8'd10;
	localparam logic [30:0] LEN_LIMIT_RESET = 31'h7FFF_FFFF;

	// ASCII characters of the length field
	localparam logic [7:0] ASCII_SPACE = 8'h20;
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_NINE  = 8'h39;

	// Result kinds
	localparam logic KIND_DATA  = 1'b0;
	localparam logic KIND_REPLY = 1'b1;

	// Reply codes
	localparam logic [1:0] RC_NOSIZE   = 2'd0;
	localparam logic [1:0] RC_OVERFLOW = 2'd1;
	localparam logic [1:0] RC_SUCCESS  = 2'd2;

	// One result item
	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       last;
		logic [1:0] code;
	} result_t;

	// Up to two results produced by one input byte
	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} push_req_t;

	function automatic result_t make_reply(input logic [1:0] code);
		result_t r;
		r.kind = KIND_REPLY;
		r.data = 8'd0;
		r.last = 1'b0;
		r.code = code;
		return r;
	endfunction

endpackage

// File: rtl/dlpd_front.sv
module dlpd_front
	import dlpd_pkg::*;
#(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      in_byte,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [30:0]     cfg_data,
	output push_req_t       req
);

	// wide enough for count * 10 + digit and for the full 31-bit limit
	localparam int NW = ((LEN_BITS + 4) > 31) ? (LEN_BITS + 4) : 31;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_LENGTH  = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [7:0]          seen_q, seen_d;
	logic [LEN_BITS-1:0] count_q, count_d;
	logic [7:0]          hdr_skip_q;
	logic [30:0]         len_limit_q;

	logic                do_len;
	logic [LEN_BITS-1:0] cur_len;
	logic [NW-1:0]       next_len;
	logic [NW-1:0]       limit_ext;
	logic [NW-1:0]       mask_ext;
	logic [NW-1:0]       limit_cap;
	logic                is_digit;
	logic [3:0]          digit;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_skip_q  <= HDR_SKIP_RESET;
			len_limit_q <= LEN_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HDR_SKIP:  hdr_skip_q  <= cfg_data[7:0];
				CFG_LEN_LIMIT: len_limit_q <= cfg_data;
				default:       hdr_skip_q  <= hdr_skip_q;
			endcase
		end
	end

	// Length arithmetic: count * 10 + digit, compared with the capped limit
	assign cur_len   = (phase_q == PH_LENGTH) ? count_q : '0;
	assign is_digit  = (in_byte >= ASCII_ZERO) && (in_byte <= ASCII_NINE);
	assign digit     = 4'(in_byte - ASCII_ZERO);
	assign next_len  = (NW'(cur_len) << 3) + (NW'(cur_len) << 1) + NW'(digit);
	assign limit_ext = NW'(len_limit_q);
	assign mask_ext  = NW'({LEN_BITS{1'b1}});
	assign limit_cap = (limit_ext > mask_ext) ? mask_ext : limit_ext;

	// Byte classification and next state
	always_comb begin
		phase_d = phase_q;
		seen_d  = seen_q;
		count_d = count_q;
		do_len  = 1'b0;
		req     = '0;
		if (accept) begin
			unique case (phase_q)
				PH_PAYLOAD: begin
					req.v0      = 1'b1;
					req.r0.kind = KIND_DATA;
					req.r0.data = in_byte;
					if (count_q <= LEN_BITS'(1)) begin
						req.r0.last = 1'b1;
						req.v1      = 1'b1;
						req.r1      = make_reply(RC_SUCCESS);
						phase_d     = PH_HEADER;
						seen_d      = '0;
						count_d     = '0;
					end else begin
						count_d = count_q - LEN_BITS'(1);
					end
				end
				PH_LENGTH: do_len = 1'b1;
				PH_HEADER: begin
					if (seen_q < hdr_skip_q) begin
						seen_d = seen_q + 8'd1;
					end else begin
						do_len = 1'b1;
					end
				end
				default: phase_d = PH_HEADER;
			endcase
		end
		if (do_len) begin
			phase_d = PH_LENGTH;
			count_d = cur_len;
			if (in_byte == ASCII_SPACE) begin
				if (cur_len == '0) begin
					req.v0  = 1'b1;
					req.r0  = make_reply(RC_SUCCESS);
					phase_d = PH_HEADER;
					seen_d  = '0;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end else if (!is_digit) begin
				req.v0  = 1'b1;
				req.r0  = make_reply(RC_NOSIZE);
				phase_d = PH_HEADER;
				seen_d  = '0;
				count_d = '0;
			end else if (next_len > limit_cap) begin
				req.v0  = 1'b1;
				req.r0  = make_reply(RC_OVERFLOW);
				phase_d = PH_HEADER;
				seen_d  = '0;
				count_d = '0;
			end else begin
				count_d = next_len[LEN_BITS-1:0];
			end
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			seen_q  <= '0;
			count_q <= '0;
		end else begin
			phase_q <= phase_d;
			seen_q  <= seen_d;
			count_q <= count_d;
		end
	end

endmodule

// File: rtl/dlpd_queue.sv
module dlpd_queue
	import dlpd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  push_req_t req,
	input  logic      pop,
	output logic      full,
	output logic      empty,
	output result_t   head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	result_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  n_push;
	logic              do_pop;

	// Room for two results is needed before a byte is taken
	assign full   = cnt_q > CNT_W'(QUEUE_DEPTH - 2);
	assign empty  = cnt_q == '0;
	assign head   = mem_q[rd_q];
	assign do_pop = pop && !empty;
	assign n_push = CNT_W'(req.v0) + CNT_W'(req.v1);

	// Storage, written one or two entries at a time
	always_ff @(posedge clk) begin
		if (req.v0) begin
			mem_q[wr_q] <= req.r0;
		end
		if (req.v1) begin
			mem_q[wr_q + PTR_W'(1)] <= req.r1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(n_push);
			rd_q  <= rd_q + PTR_W'(do_pop);
			cnt_q <= cnt_q + n_push - CNT_W'(do_pop);
		end
	end

endmodule

// File: rtl/decimal_length_prefix_deframer.sv
// A result is registered in the queue when its byte is taken.
// Throughput: one byte per cycle while full is low; the final payload byte
// of a message yields two results, so the output side drains one result per pop
// from a 4-entry queue. full rises while fewer than two queue entries are free.
// Reset (arst_n low, asynchronous): queue empty, parser at header skip,
// header_skip_count = 10, length_limit = 2147483647.
module decimal_length_prefix_deframer
	import dlpd_pkg::*;
#(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	output logic        empty,
	input  logic        pop,
	output logic        out_kind,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic [1:0]  reply_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [30:0] cfg_data
);

	push_req_t req;
	result_t   head;

	assign cfg_ready = 1'b1;

	// Front: parse and classify each byte
	dlpd_front #(
		.LEN_BITS(LEN_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (push && !full),
		.in_byte  (in_byte),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req)
	);

	// Back: result queue toward the consumer
	dlpd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.pop   (pop),
		.full  (full),
		.empty (empty),
		.head  (head)
	);

	assign out_kind   = head.kind;
	assign out_byte   = head.data;
	assign out_last   = head.last;
	assign reply_code = head.code;

endmodule

// File: rtl/dlpd_checker.sv
module dlpd_checker
	import dlpd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       out_kind,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic [1:0] reply_code
);

	// A reply carries no byte and no last flag
	a_reply_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_kind == KIND_REPLY) |-> (out_byte == 8'd0 && !out_last))
		else $error("reply carries payload fields");

	// A payload byte carries no reply code
	a_data_code: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_kind == KIND_DATA) |-> (reply_code == RC_NOSIZE))
		else $error("payload byte carries a reply code");

	// The final payload byte is followed at once by a success reply
	a_last_success: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && out_kind == KIND_DATA && out_last) |=>
		(!empty && out_kind == KIND_REPLY && reply_code == RC_SUCCESS))
		else $error("final byte not followed by success reply");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_kind) && $stable(out_byte)
		&& $stable(out_last) && $stable(reply_code)))
		else $error("stalled result changed");

endmodule

bind decimal_length_prefix_deframer dlpd_checker u_dlpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.empty     (empty),
	.pop       (pop),
	.out_kind  (out_kind),
	.out_byte  (out_byte),
	.out_last  (out_last),
	.reply_code(reply_code)
);

// File: dv/deframe_checker.sv
module deframe_checker
	import dlpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  in_byte,
	input  logic        empty,
	input  logic        pop,
	input  logic        out_kind,
	input  logic [7:0]  out_byte,
	input  logic        out_last,
	input  logic [1:0]  reply_code,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [30:0] cfg_data,
	output int          mismatches,
	output int          results_due,
	output logic        at_frame_start
);

	typedef enum logic [1:0] {PH_HEADER, PH_LENGTH, PH_PAYLOAD} parse_phase_t;

	// code field carried by payload bytes
	localparam logic [1:0] NO_CODE = 2'd0;

	// parser copy and its register copies
	parse_phase_t phase;
	logic [7:0]   hdr_skip;
	logic [7:0]   hdr_seen;
	logic [30:0]  len_limit;
	logic [30:0]  len_count;

	// results predicted but not yet popped, oldest first
	result_t due_q[$];

	task automatic queue_result(input logic kind, input logic [7:0] data, input logic last,
			input logic [1:0] code);
		result_t r;
		r.kind = kind;
		r.data = data;
		r.last = last;
		r.code = code;
		due_q.insert(due_q.size(), r);
	endtask

	// a reply ends the message, parser goes back to header skip
	task automatic queue_reply(input logic [1:0] code);
		queue_result(KIND_REPLY, 8'd0, 1'b0, code);
		phase = PH_HEADER;
		hdr_seen = 8'd0;
		len_count = '0;
	endtask

	// one received byte through the parser
	task automatic deframe_byte(input logic [7:0] b);
		longint unsigned grown;
		bit take;
		take = 1'b1;
		if (phase == PH_PAYLOAD) begin
			take = 1'b0;
			if (len_count <= 31'd1) begin
				queue_result(KIND_DATA, b, 1'b1, NO_CODE);
				queue_reply(RC_SUCCESS);
			end else begin
				queue_result(KIND_DATA, b, 1'b0, NO_CODE);
				len_count = len_count - 31'd1;
			end
		end else if (phase != PH_LENGTH) begin
			// header skip; count may have been lowered below hdr_seen
			if (hdr_seen < hdr_skip) begin
				hdr_seen = hdr_seen + 8'd1;
				take = 1'b0;
			end else begin
				phase = PH_LENGTH;
				len_count = '0;
			end
		end
		if (take) begin
			if (b == ASCII_SPACE) begin
				if (len_count == '0)
					queue_reply(RC_SUCCESS);
				else
					phase = PH_PAYLOAD;
			end else if (b < ASCII_ZERO || b > ASCII_NINE) begin
				queue_reply(RC_NOSIZE);
			end else begin
				// exact compare against the limit, no wrap
				grown = 64'(len_count) * 10 + 64'(b - ASCII_ZERO);
				if (grown > 64'(len_limit))
					queue_reply(RC_OVERFLOW);
				else
					len_count = grown[30:0];
			end
		end
	endtask

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	task automatic check_popped();
		result_t want;
		if (due_q.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected result, expected none actual kind=%0d byte=%0h last=%0d code=%0d",
				$time, out_kind, out_byte, out_last, reply_code);
		end else begin
			want = due_q.pop_front();
			compare_field("out_kind", want.kind, out_kind);
			compare_field("out_byte", want.data, out_byte);
			compare_field("out_last", want.last, out_last);
			compare_field("reply_code", want.code, reply_code);
		end
	endtask

	// watch all three channels; pops are checked before the new byte is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_HEADER;
			hdr_seen = 8'd0;
			len_count = '0;
			hdr_skip = HDR_SKIP_RESET;
			len_limit = LEN_LIMIT_RESET;
			due_q.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_HDR_SKIP)
					hdr_skip = cfg_data[7:0];
				else
					len_limit = cfg_data;
			end
			if (pop && !empty)
				check_popped();
			if (push && !full)
				deframe_byte(in_byte);
		end
		results_due <= due_q.size();
		at_frame_start <= (phase == PH_HEADER) && (hdr_seen == 8'd0);
	end

endmodule

// File: dv/tb.sv
module tb
	import dlpd_pkg::*;
;

	localparam int ITEM_TARGET = 1550;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD   = 400;
	// ':' sits just above '9', so it never extends a length
	localparam logic [7:0] FILL_BYTE  = 8'h3A;
	// '/' sits just below '0'
	localparam logic [7:0] SLASH_BYTE = 8'h2F;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  in_byte;
	logic        empty;
	logic        pop;
	logic        out_kind;
	logic [7:0]  out_byte;
	logic        out_last;
	logic [1:0]  reply_code;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [30:0] cfg_data;

	int          mismatches;
	int          results_due;
	logic        at_frame_start;

	// sender-side view of the current settings
	logic [7:0]  cur_hdr;
	logic [30:0] cur_limit;
	int          burst_left;
	int          body_cnt;
	int          quiet_cycles;

	decimal_length_prefix_deframer i_dut (.*);

	deframe_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// one byte transaction; gaps fall between bursts
	task automatic send_byte(input logic [7:0] b, input bit body);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		push <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		burst_left--;
		if (body)
			body_cnt++;
	endtask

	// header bytes count toward the item total too
	task automatic send_header();
		repeat (cur_hdr) send_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// decimal digits of v, at most max_digits, stopping once the limit is passed
	task automatic send_number(input longint unsigned v, input int max_digits);
		byte unsigned digs[$];
		longint unsigned acc;
		bit over;
		do begin
			digs.push_front(byte'(v % 10));
			v = v / 10;
		end while (v != 0);
		acc = 0;
		over = 1'b0;
		for (int i = 0; i < digs.size() && i < max_digits && !over; i++) begin
			send_byte(ASCII_ZERO + 8'(digs[i]), 1'b1);
			acc = acc * 10 + digs[i];
			over = acc > 64'(cur_limit);
		end
	endtask

	task automatic stop_and_drain();
		push <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// both registers written back to back once the output queue is drained
	task automatic configure(input logic [7:0] hdr, input logic [30:0] lim);
		stop_and_drain();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_HDR_SKIP;
		cfg_data <= {23'd0, hdr};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= CFG_LEN_LIMIT;
		cfg_data <= lim;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_hdr = hdr;
		cur_limit = lim;
	endtask

	// receiver: changing stall pattern, plus long hold-offs so the queue fills
	initial begin
		int pops;
		int mode;
		int tick;
		logic [7:0] pat;
		pop <= 1'b0;
		pops = 0;
		mode = 0;
		tick = 0;
		pat = 8'hFF;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				pops++;
				if (pops % 600 == 250) begin
					pop <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
				end
			end
			if (tick % 50 == 0) begin
				mode = $urandom_range(0, 2);
				pat = 8'($urandom);
			end
			tick++;
			case (mode)
				0: pop <= 1'b1;
				1: begin
					pop <= pat[0];
					pat = {pat[0], pat[7:1]};
				end
				default: pop <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		int p;
		int budget;
		int sel;
		longint unsigned n;
		logic [7:0] b;
		logic [7:0] hdr;
		logic [30:0] lim;

		arst_n <= 1'b0;
		push <= 1'b0;
		in_byte <= 8'd0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_HDR_SKIP;
		cfg_data <= '0;
		cur_hdr = HDR_SKIP_RESET;
		cur_limit = LEN_LIMIT_RESET;
		burst_left = 0;
		body_cnt = 0;
		quiet_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// header count lowered while the header is being skipped
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		configure(8'd2, LEN_LIMIT_RESET);
		send_byte(ASCII_ZERO + 8'd1, 1'b1);
		send_byte(ASCII_SPACE, 1'b1);
		send_byte(8'h80, 1'b1);

		// no header; empty length, zero length, bad digits, overflow, short payload
		configure(8'd0, 31'd9);
		send_byte(ASCII_SPACE, 1'b1);
		send_byte(ASCII_ZERO, 1'b1);
		send_byte(ASCII_SPACE, 1'b1);
		send_byte(FILL_BYTE, 1'b1);
		send_byte(SLASH_BYTE, 1'b1);
		send_byte(ASCII_ZERO + 8'd1, 1'b1);
		send_byte(ASCII_ZERO + 8'd2, 1'b1);
		send_byte(ASCII_ZERO + 8'd2, 1'b1);
		send_byte(ASCII_SPACE, 1'b1);
		send_byte(8'h00, 1'b1);
		send_byte(8'h7F, 1'b1);

		// zero limit: any nonzero digit overflows, leading zeros are fine
		configure(8'd0, 31'd0);
		send_byte(ASCII_ZERO + 8'd1, 1'b1);
		send_byte(ASCII_ZERO, 1'b1);
		send_byte(ASCII_ZERO, 1'b1);
		send_byte(ASCII_SPACE, 1'b1);

		// random messages over a rotation of settings
		body_cnt = 0;
		p = 0;
		while (body_cnt < ITEM_TARGET) begin
			case (p % 8)
				0: begin hdr = 8'd0;   lim = LEN_LIMIT_RESET; end
				1: begin hdr = 8'd255; lim = 31'd40; end
				2: begin hdr = 8'd3;   lim = 31'd0; end
				3: begin hdr = 8'd1;   lim = 31'd9; end
				4: begin hdr = 8'd7;   lim = 31'd100; end
				5: begin hdr = 8'd0;   lim = 31'd15; end
				6: begin hdr = 8'd2;   lim = LEN_LIMIT_RESET; end
				default: begin hdr = HDR_SKIP_RESET; lim = LEN_LIMIT_RESET - 31'd1; end
			endcase
			configure(hdr, lim);
			budget = body_cnt + ((hdr > 8'd64) ? 40 : 190);
			while (body_cnt < budget && body_cnt < ITEM_TARGET) begin
				sel = $urandom_range(0, 99);
				if (sel < 72) begin
					// well-formed message, mostly short payloads
					sel = $urandom_range(0, 99);
					n = (sel < 70) ? $urandom_range(0, 12) :
						(sel < 95) ? $urandom_range(13, 40) : $urandom_range(41, 120);
					if (n > 64'(cur_limit))
						n = $urandom_range(0, cur_limit);
					send_header();
					if (n != 0 || $urandom_range(0, 1) == 0) begin
						repeat (($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0)
							send_byte(ASCII_ZERO, 1'b1);
						send_number(n, 32);
					end
					send_byte(ASCII_SPACE, 1'b1);
					repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b1);
				end else if (sel < 82) begin
					// some valid digits, then a byte that is neither digit nor space
					send_header();
					n = $urandom_range(0, (cur_limit < 31'd9999) ? cur_limit : 31'd9999);
					send_number(n, $urandom_range(0, 5));
					do
						b = 8'($urandom_range(0, 255));
					while (b == ASCII_SPACE || (b >= ASCII_ZERO && b <= ASCII_NINE));
					send_byte(b, 1'b1);
				end else if (sel < 92) begin
					// length past the limit, by one to a thousand
					send_header();
					send_number(64'(cur_limit) + 1 + $urandom_range(0, 999), 32);
				end else begin
					// raw noise, then fill until the parser is back at a message start
					repeat ($urandom_range(1, 4)) begin
						sel = $urandom_range(0, 9);
						if (sel < 4)
							b = ASCII_ZERO + 8'($urandom_range(0, 9));
						else if (sel < 6)
							b = ASCII_SPACE;
						else
							b = 8'($urandom_range(0, 255));
						send_byte(b, 1'b1);
					end
					push <= 1'b0;
					@(posedge clk);
					while (!at_frame_start) begin
						send_byte(FILL_BYTE, 1'b1);
						push <= 1'b0;
						@(posedge clk);
					end
				end
			end
			p++;
		end

		stop_and_drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && results_due == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// File: decimal_length_prefix_deframer.f
rtl/dlpd_pkg.sv
rtl/dlpd_front.sv
rtl/dlpd_queue.sv
rtl/decimal_length_prefix_deframer.sv
rtl/dlpd_checker.sv
dv/deframe_checker.sv
dv/tb.sv
